// ===== design/variable_record_ring_buffer_assert.svh =====
// Assertion macros for the record ring buffer.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`define VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH

// Flag any cycle on which cond holds outside reset.
`define VRRB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Flag a cycle on which a holds and b does not.
`define VRRB_IMPLIES(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`endif

// ===== design/vrrb_pkg.sv =====
// Shared types, codes and constants of the record ring buffer.
// No dependencies; used by every module of the block.
`default_nettype none

package vrrb_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int HDR_BYTES   = 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PTR_W       = 13;
  localparam int TAG_N       = (HDR_BYTES - 2 > 4) ? 4 : HDR_BYTES - 2;
  localparam int RD_N        = 2 + TAG_N;
  localparam int RD_IDX_W    = $clog2(RD_N);
  localparam int CNT_W       = $clog2(HDR_BYTES + 1);
  localparam int MIN_SIZE    = 16;

  localparam logic [1:0] K_PROD_HDR  = 2'd0;
  localparam logic [1:0] K_PROD_DATA = 2'd1;
  localparam logic [1:0] K_CONS_HDR  = 2'd2;
  localparam logic [1:0] K_CONS_DATA = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SPACE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SEQ   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] package_size;
    logic [31:0] tag;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] record_size;
    logic [31:0] record_tag;
    logic [7:0]  read_byte;
    logic        last_byte;
  } result_t;

  // Front-to-back handshake of one queued item.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queued_t;

  // Byte idx of a stored header: size low, size high, tag bytes, zero pad.
  function automatic logic [7:0] hdr_byte(input logic [12:0] size,
                                          input logic [31:0] tag,
                                          input logic [CNT_W-1:0] idx);
    logic [7:0] v;
    v = 8'd0;
    if (idx == CNT_W'(0)) v = size[7:0];
    else if (idx == CNT_W'(1)) v = {3'd0, size[12:8]};
    else begin
      for (int i = 0; i < TAG_N; i++) begin
        if (idx == CNT_W'(2 + i)) v = tag[8*i +: 8];
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/vrrb_front.sv =====
// Front of the record ring buffer: a four-deep queue of accepted items.
// Depends on vrrb_pkg.
`default_nettype none

module vrrb_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire vrrb_pkg::item_t item,
  output logic                 full,
  output vrrb_pkg::queued_t    head_item,
  input  wire logic            take
);

  localparam int DEPTH = 4;
  localparam int IDX_W = $clog2(DEPTH);

  vrrb_pkg::item_t entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W:0]   count;
  logic             do_push;
  logic             do_take;

  assign full    = (count == (IDX_W+1)'(DEPTH));
  assign do_push = push && !full;
  assign do_take = take && (count != '0);

  assign head_item.valid = (count != '0);
  assign head_item.item  = entries[rd_ptr];

  // Store an accepted beat.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= item;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_take) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/vrrb_engine.sv =====
// Back of the record ring buffer: sequencer, byte store and result register.
// Depends on vrrb_pkg.
`default_nettype none

module vrrb_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [12:0]       cfg_data,
  input  wire vrrb_pkg::queued_t head_item,
  output logic                   take,
  output vrrb_pkg::result_t      result,
  output logic                   empty,
  input  wire logic              pop
);

  localparam int PW = vrrb_pkg::PTR_W;
  localparam int CW = vrrb_pkg::CNT_W;
  localparam int AW = vrrb_pkg::ADDR_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PH_CHECK = 3'd1;
  localparam logic [2:0] S_PH_WRITE = 3'd2;
  localparam logic [2:0] S_CH_PLACE = 3'd3;
  localparam logic [2:0] S_CH_READ  = 3'd4;
  localparam logic [2:0] S_CH_CHECK = 3'd5;
  localparam logic [2:0] S_RD_DATA  = 3'd6;

  localparam logic [PW-1:0] H = PW'(vrrb_pkg::HDR_BYTES);

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  vrrb_pkg::item_t cur;
  logic [PW-1:0]   bsize;
  logic [PW-1:0]   head, tail;
  logic [PW-1:0]   wr_point, wr_left, rd_point, rd_left;
  logic [PW-1:0]   part1, part2, hdr_at, data_at;
  logic            first_fit, last_q;
  logic [7:0]      hb [vrrb_pkg::RD_N];
  logic            out_valid;
  vrrb_pkg::result_t out_data;

  logic [7:0]      mem [vrrb_pkg::STORE_BYTES];
  logic [7:0]      mem_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  logic            out_free;
  logic [PW-1:0]   cnt_ext;
  logic [PW-1:0]   cfg_clamped;
  logic [12:0]     rec_size;
  logic [31:0]     rec_tag;
  logic [CW-1:0]   cnt_m1;
  vrrb_pkg::item_t in_it;

  // Produce placement terms.
  logic            p_ge, p_fit1, p_fit2, p_in1, p_in2, p_fit2_all;
  logic [PW-1:0]   p_part1, p_part2;
  // Consume placement terms.
  logic [PW-1:0]   c_part1, c_part2;

  assign in_it    = head_item.item;
  assign out_free = !out_valid || pop;
  assign take     = head_item.valid && (state == S_IDLE) && out_free;
  assign empty    = !out_valid;
  assign result   = out_data;
  assign cnt_ext  = {{(PW-CW){1'b0}}, cnt};
  assign cnt_m1   = cnt - 1'b1;

  // Clamp the configured size to the store.
  always_comb begin
    if (cfg_data > PW'(vrrb_pkg::STORE_BYTES)) cfg_clamped = PW'(vrrb_pkg::STORE_BYTES);
    else if (cfg_data < PW'(vrrb_pkg::MIN_SIZE)) cfg_clamped = PW'(vrrb_pkg::MIN_SIZE);
    else cfg_clamped = cfg_data;
  end

  // Free space around the head for a new record.
  always_comb begin
    p_ge = (head >= tail);
    if (p_ge) begin
      p_part1 = bsize - head;
      p_part2 = (tail != '0) ? tail - 1'b1 : '0;
    end else begin
      p_part1 = tail - head - 1'b1;
      p_part2 = '0;
    end
    p_fit1     = (H <= p_part1);
    p_fit2     = (H <= p_part2);
    p_in1      = (cur.package_size <= p_part1 - H);
    p_in2      = (cur.package_size <= p_part2);
    p_fit2_all = (cur.package_size <= p_part2 - H);
  end

  // Occupied space from the tail.
  always_comb begin
    if (head > tail) begin
      c_part1 = head - tail;
      c_part2 = '0;
    end else begin
      c_part1 = bsize - tail;
      c_part2 = head;
    end
  end

  // Assemble the fetched header.
  always_comb begin
    rec_size = {hb[1][4:0], hb[0]};
    rec_tag  = '0;
    for (int i = 0; i < vrrb_pkg::TAG_N; i++) begin
      rec_tag[8*i +: 8] = hb[2+i];
    end
  end

  // Drive the store ports.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_point[AW-1:0];
    mem_wdata = in_it.data_byte;
    mem_re    = 1'b0;
    mem_raddr = rd_point[AW-1:0];
    if (state == S_PH_WRITE) begin
      mem_we    = (cnt < CW'(vrrb_pkg::HDR_BYTES));
      mem_waddr = AW'(hdr_at + cnt_ext);
      mem_wdata = vrrb_pkg::hdr_byte(cur.package_size, cur.tag, cnt);
    end else if (take && in_it.kind == vrrb_pkg::K_PROD_DATA) begin
      mem_we = (wr_left != '0);
    end
    if (state == S_CH_READ) begin
      mem_re    = (cnt < CW'(vrrb_pkg::RD_N));
      mem_raddr = AW'(hdr_at + cnt_ext);
    end else if (take && in_it.kind == vrrb_pkg::K_CONS_DATA) begin
      mem_re = (rd_left != '0);
    end
  end

  // Byte store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  // Sequence items and emit results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      bsize     <= PW'(vrrb_pkg::STORE_BYTES);
      head      <= '0;
      tail      <= '0;
      wr_point  <= '0;
      wr_left   <= '0;
      rd_point  <= '0;
      rd_left   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (cfg_write) begin
        bsize    <= cfg_clamped;
        head     <= '0;
        tail     <= '0;
        wr_point <= '0;
        wr_left  <= '0;
        rd_point <= '0;
        rd_left  <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (take) begin
              cur      <= in_it;
              out_data <= '0;
              cnt      <= '0;
              unique case (in_it.kind)
                vrrb_pkg::K_PROD_HDR: begin
                  if (wr_left != '0) begin
                    out_data.status <= vrrb_pkg::ST_SEQ;
                    out_valid       <= 1'b1;
                  end else begin
                    state <= S_PH_CHECK;
                  end
                end
                vrrb_pkg::K_PROD_DATA: begin
                  out_valid <= 1'b1;
                  if (wr_left == '0) begin
                    out_data.status <= vrrb_pkg::ST_SEQ;
                  end else begin
                    wr_point <= wr_point + 1'b1;
                    wr_left  <= wr_left - 1'b1;
                    if (wr_left == PW'(1)) begin
                      head               <= wr_point + 1'b1;
                      out_data.last_byte <= 1'b1;
                    end
                  end
                end
                vrrb_pkg::K_CONS_HDR: begin
                  if (rd_left != '0) begin
                    out_data.status <= vrrb_pkg::ST_SEQ;
                    out_valid       <= 1'b1;
                  end else begin
                    state <= S_CH_PLACE;
                  end
                end
                default: begin
                  if (rd_left == '0) begin
                    out_data.status <= vrrb_pkg::ST_SEQ;
                    out_valid       <= 1'b1;
                  end else begin
                    rd_point <= rd_point + 1'b1;
                    rd_left  <= rd_left - 1'b1;
                    last_q   <= (rd_left == PW'(1));
                    if (rd_left == PW'(1)) tail <= rd_point + 1'b1;
                    state <= S_RD_DATA;
                  end
                end
              endcase
            end
          end
          S_PH_CHECK: begin
            priority if (p_fit1 && (p_in1 || p_in2)) begin
              hdr_at  <= head;
              data_at <= p_in1 ? head + H : '0;
              state   <= S_PH_WRITE;
            end else if (!p_fit1 && p_fit2 && p_fit2_all) begin
              hdr_at  <= '0;
              data_at <= H;
              state   <= S_PH_WRITE;
            end else if (out_free) begin
              out_data.status <= vrrb_pkg::ST_SPACE;
              out_valid       <= 1'b1;
              state           <= S_IDLE;
            end
          end
          S_PH_WRITE: begin
            if (cnt < CW'(vrrb_pkg::HDR_BYTES)) begin
              cnt <= cnt + 1'b1;
            end else if (out_free) begin
              wr_point  <= data_at;
              wr_left   <= cur.package_size;
              if (cur.package_size == '0) head <= data_at;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
          S_CH_PLACE: begin
            part1 <= c_part1;
            part2 <= c_part2;
            priority if (head == tail) begin
              if (out_free) begin
                out_data.status <= vrrb_pkg::ST_EMPTY;
                out_valid       <= 1'b1;
                state           <= S_IDLE;
              end
            end else if (H <= c_part1) begin
              hdr_at    <= tail;
              first_fit <= 1'b1;
              state     <= S_CH_READ;
            end else if (H <= c_part2) begin
              hdr_at    <= '0;
              first_fit <= 1'b0;
              state     <= S_CH_READ;
            end else if (out_free) begin
              out_data.status <= vrrb_pkg::ST_SPACE;
              out_valid       <= 1'b1;
              state           <= S_IDLE;
            end
          end
          S_CH_READ: begin
            if (cnt != '0) hb[cnt_m1[vrrb_pkg::RD_IDX_W-1:0]] <= mem_q;
            if (cnt == CW'(vrrb_pkg::RD_N)) state <= S_CH_CHECK;
            else cnt <= cnt + 1'b1;
          end
          S_CH_CHECK: begin
            if (out_free) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
              priority if (first_fit && rec_size <= part1 - H) begin
                rd_point <= tail + H;
                rd_left  <= rec_size;
                if (rec_size == '0) tail <= tail + H;
                out_data.record_size <= rec_size;
                out_data.record_tag  <= rec_tag;
              end else if (first_fit ? (rec_size <= part2)
                                     : (rec_size <= part2 - H)) begin
                rd_point <= first_fit ? '0 : H;
                rd_left  <= rec_size;
                if (rec_size == '0) tail <= first_fit ? '0 : H;
                out_data.record_size <= rec_size;
                out_data.record_tag  <= rec_tag;
              end else begin
                out_data.status <= vrrb_pkg::ST_SPACE;
              end
            end
          end
          S_RD_DATA: begin
            out_data.read_byte <= mem_q;
            out_data.last_byte <= last_q;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/variable_record_ring_buffer.sv =====
// Top level of the variable-length record ring buffer.
// Depends on vrrb_pkg, vrrb_front, vrrb_engine and the assertion header.
//
// Records of a header (payload size, tag) plus payload live in a byte ring of
// buffer_size bytes. Items enter a four-deep queue and are executed one at a
// time by a sequencer around a single-port-write, registered-read byte store;
// each item yields one result held in an output register, so pushing goes on
// while a result waits. A payload read passes through the registered store
// read; a produce header writes the store one byte at a time and a consume
// header reads its size and tag bytes one at a time. No clearing pass: the
// store is valid only where written. Write buffer_size only while idle; it
// clamps to 16..4096 and empties the ring.
`default_nettype none

`include "variable_record_ring_buffer_assert.svh"

module variable_record_ring_buffer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire vrrb_pkg::item_t item,
  output logic                 full,
  output logic                 empty,
  input  wire logic            pop,
  output vrrb_pkg::result_t    result,
  input  wire logic            cfg_write,
  input  wire logic [12:0]     cfg_data
);

  vrrb_pkg::queued_t head_item;
  logic              take;

  vrrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .head_item (head_item),
    .take      (take)
  );

  vrrb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .head_item (head_item),
    .take      (take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  // Check result fields against status, the take handshake and that a waiting result holds.
  `VRRB_IMPLIES(a_last_ok, !empty && result.last_byte, result.status == vrrb_pkg::ST_OK, "last byte on a failed beat")
  `VRRB_IMPLIES(a_hdr_ok, !empty && (result.record_size != '0 || result.record_tag != '0), result.status == vrrb_pkg::ST_OK, "header fields on a failed beat")
  `VRRB_NEVER(a_take_empty, take && !head_item.valid, "engine took from an empty queue")
  `VRRB_IMPLIES(a_hold, !empty && !pop, ##1 !empty && $stable(result), "waiting result changed")

endmodule

`default_nettype wire

// ===== bench/variable_record_ring_buffer_tb.sv =====
// Self-checking bench for the variable-length record ring buffer.
// Drives produce/consume records through the queue ports and checks every beat.
// Depends on vrrb_pkg and the variable_record_ring_buffer top level.
`default_nettype none

module variable_record_ring_buffer_tb;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  vrrb_pkg::item_t   item = '0;
  logic              full;
  logic              empty;
  logic              pop = 1'b0;
  vrrb_pkg::result_t result;
  logic              cfg_write = 1'b0;
  logic [12:0]       cfg_data = 13'd0;

  variable_record_ring_buffer u_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .empty(empty), .pop(pop), .result(result),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Ring state, two copies: 0 checks accepted beats, 1 shapes the stimulus.
  logic [7:0]  ring_bytes [2][vrrb_pkg::STORE_BYTES];
  int unsigned ring_head [2];
  int unsigned ring_tail [2];
  int unsigned wr_at [2];
  int unsigned wr_left [2];
  int unsigned rd_at [2];
  int unsigned rd_left [2];
  int unsigned ring_size_reg [2];

  vrrb_pkg::item_t   pending_items[$];
  vrrb_pkg::result_t predicted_results[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_req = 0;
  int      hold_off_left = 0;
  logic    took = 1'b0;

  function automatic void ring_restart(input int s, input int unsigned value);
    ring_size_reg[s] = value & 13'h1FFF;
    ring_head[s] = 0; ring_tail[s] = 0;
    wr_at[s] = 0; wr_left[s] = 0; rd_at[s] = 0; rd_left[s] = 0;
  endfunction

  function automatic int unsigned ring_used(input int s);
    int unsigned b;
    b = ring_size_reg[s];
    if (b > vrrb_pkg::STORE_BYTES) b = vrrb_pkg::STORE_BYTES;
    if (b < vrrb_pkg::MIN_SIZE) b = vrrb_pkg::MIN_SIZE;
    return b;
  endfunction

  function automatic void ring_put(input int s, input int unsigned at, input logic [7:0] v);
    if (at < vrrb_pkg::STORE_BYTES) ring_bytes[s][at] = v;
  endfunction

  function automatic logic [7:0] ring_get(input int s, input int unsigned at);
    return (at < vrrb_pkg::STORE_BYTES) ? ring_bytes[s][at] : 8'd0;
  endfunction

  // Compute the result of one beat and advance ring copy s.
  function automatic vrrb_pkg::result_t ring_step(input int s, input vrrb_pkg::item_t it);
    vrrb_pkg::result_t r;
    int unsigned b, hd, tl, p1, p2, hdr_at, dat_at, sz;
    logic [31:0] tg;
    r = '0;
    b = ring_used(s);
    hd = (ring_head[s] > b) ? b : ring_head[s];
    tl = (ring_tail[s] > b) ? b : ring_tail[s];
    case (it.kind)
      vrrb_pkg::K_PROD_HDR: begin
        if (wr_left[s] != 0) begin
          r.status = vrrb_pkg::ST_SEQ;
          return r;
        end
        if (hd >= tl) begin
          p1 = b - hd;
          p2 = (tl > 0) ? tl - 1 : 0;
        end else begin
          p1 = tl - hd - 1;
          p2 = 0;
        end
        sz = it.package_size;
        if (vrrb_pkg::HDR_BYTES <= p1) begin
          hdr_at = hd;
          if (sz <= p1 - vrrb_pkg::HDR_BYTES) dat_at = hd + vrrb_pkg::HDR_BYTES;
          else if (sz <= p2) dat_at = 0;
          else begin
            r.status = vrrb_pkg::ST_SPACE;
            return r;
          end
        end else if (vrrb_pkg::HDR_BYTES <= p2 && sz <= p2 - vrrb_pkg::HDR_BYTES) begin
          hdr_at = 0;
          dat_at = vrrb_pkg::HDR_BYTES;
        end else begin
          r.status = vrrb_pkg::ST_SPACE;
          return r;
        end
        for (int i = 0; i < vrrb_pkg::HDR_BYTES; i++) ring_put(s, hdr_at + i, 8'd0);
        ring_put(s, hdr_at, sz[7:0]);
        ring_put(s, hdr_at + 1, {3'd0, sz[12:8]});
        for (int i = 0; i < vrrb_pkg::TAG_N; i++)
          ring_put(s, hdr_at + 2 + i, it.tag[8*i +: 8]);
        wr_at[s] = dat_at;
        wr_left[s] = sz;
        if (sz == 0) ring_head[s] = dat_at;
        r.status = vrrb_pkg::ST_OK;
      end
      vrrb_pkg::K_PROD_DATA: begin
        if (wr_left[s] == 0) begin
          r.status = vrrb_pkg::ST_SEQ;
          return r;
        end
        ring_put(s, wr_at[s], it.data_byte);
        wr_at[s]++;
        wr_left[s]--;
        if (wr_left[s] == 0) begin
          ring_head[s] = wr_at[s];
          r.last_byte = 1'b1;
        end
      end
      vrrb_pkg::K_CONS_HDR: begin
        if (rd_left[s] != 0) begin
          r.status = vrrb_pkg::ST_SEQ;
          return r;
        end
        if (hd == tl) begin
          r.status = vrrb_pkg::ST_EMPTY;
          return r;
        end
        if (hd > tl) begin
          p1 = hd - tl; p2 = 0;
        end else begin
          p1 = b - tl; p2 = hd;
        end
        if (vrrb_pkg::HDR_BYTES <= p1) hdr_at = tl;
        else if (vrrb_pkg::HDR_BYTES <= p2) hdr_at = 0;
        else begin
          r.status = vrrb_pkg::ST_SPACE;
          return r;
        end
        sz = 32'({ring_get(s, hdr_at + 1), ring_get(s, hdr_at)});
        tg = '0;
        for (int i = 0; i < vrrb_pkg::TAG_N; i++) tg[8*i +: 8] = ring_get(s, hdr_at + 2 + i);
        if (hdr_at == tl && vrrb_pkg::HDR_BYTES <= p1) begin
          if (sz <= p1 - vrrb_pkg::HDR_BYTES) dat_at = tl + vrrb_pkg::HDR_BYTES;
          else if (sz <= p2) dat_at = 0;
          else begin
            r.status = vrrb_pkg::ST_SPACE;
            return r;
          end
        end else begin
          if (sz > p2 - vrrb_pkg::HDR_BYTES) begin
            r.status = vrrb_pkg::ST_SPACE;
            return r;
          end
          dat_at = vrrb_pkg::HDR_BYTES;
        end
        rd_at[s] = dat_at;
        rd_left[s] = sz;
        if (sz == 0) ring_tail[s] = dat_at;
        r.status = vrrb_pkg::ST_OK;
        r.record_size = sz[12:0];
        r.record_tag = tg;
      end
      default: begin
        if (rd_left[s] == 0) begin
          r.status = vrrb_pkg::ST_SEQ;
          return r;
        end
        r.read_byte = ring_get(s, rd_at[s]);
        rd_at[s]++;
        rd_left[s]--;
        if (rd_left[s] == 0) begin
          ring_tail[s] = rd_at[s];
          r.last_byte = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Queue one beat, stepping the stimulus copy so follow-on beats fit.
  task automatic queue_beat(input logic [1:0] k, input logic [12:0] sz,
                            input logic [31:0] tg, input logic [7:0] d);
    vrrb_pkg::item_t   it;
    vrrb_pkg::result_t unused;
    it.kind = k; it.package_size = sz; it.tag = tg; it.data_byte = d;
    unused = ring_step(1, it);
    pending_items.push_back(it);
  endtask

  task automatic queue_produce(input logic [12:0] sz);
    queue_beat(vrrb_pkg::K_PROD_HDR, sz, $urandom, 8'($urandom));
    while (wr_left[1] != 0)
      queue_beat(vrrb_pkg::K_PROD_DATA, 13'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic queue_consume();
    queue_beat(vrrb_pkg::K_CONS_HDR, 13'($urandom), $urandom, 8'($urandom));
    while (rd_left[1] != 0)
      queue_beat(vrrb_pkg::K_CONS_DATA, 13'($urandom), $urandom, 8'($urandom));
  endtask

  // Mostly whole records with random content, some noise and torn sequences.
  task automatic queue_random(input int n);
    int r;
    int unsigned lim;
    repeat (n) begin
      r = $urandom_range(0, 99);
      lim = ring_used(1);
      if (r < 45) begin
        // Oversize records are refused in a single beat.
        if ($urandom_range(0, 9) == 0) queue_produce(13'($urandom_range(lim, 4096)));
        else queue_produce(13'($urandom_range(0, 12)));
      end else if (r < 88) begin
        queue_consume();
      end else if (r < 94) begin
        queue_beat(2'($urandom), 13'($urandom), $urandom, 8'($urandom));
      end else if (r < 97) begin
        queue_beat(vrrb_pkg::K_PROD_HDR, 13'($urandom_range(1, 6)), $urandom, 8'($urandom));
      end else begin
        queue_beat(vrrb_pkg::K_CONS_HDR, 13'($urandom), $urandom, 8'($urandom));
      end
    end
  endtask

  // Wait for a drained block, then load a new ring size in both copies.
  task automatic load_ring_size(input logic [12:0] v);
    wait (pending_items.size() == 0 && predicted_results.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    ring_restart(0, 32'(v));
    ring_restart(1, 32'(v));
  endtask

  // Offer beats at the falling edge; hold an offer until it is taken.
  always @(negedge clk) begin
    if (!(push && !took)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        item <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Accept beats at the rising edge and predict their results.
  always @(posedge clk) begin
    took <= !rst && push && !full;
    if (!rst && push && !full) begin
      predicted_results.push_back(ring_step(0, pending_items[0]));
      void'(pending_items.pop_front());
    end
  end

  // Drive pop with random stalls and an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_off_req != 0 && hold_off_left == 0) begin
      hold_off_left <= hold_off_req;
      hold_off_req <= 0;
      pop <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    vrrb_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %p", result);
      end else begin
        want = predicted_results.pop_front();
        if (result.status !== want.status || result.record_size !== want.record_size ||
            result.record_tag !== want.record_tag || result.read_byte !== want.read_byte ||
            result.last_byte !== want.last_byte) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch: expected %p actual %p", want, result);
        end
      end
    end
  end

  initial begin
    int cycles;
    logic [12:0] sizes [8];
    int idle_modes [8];
    int stall_modes [8];
    sizes = '{13'd4096, 13'd16, 13'd8191, 13'd0, 13'd100, 13'd37, 13'd4095, 13'd64};
    idle_modes = '{0, 78, 0, 31, 0, 78, 0, 31};
    stall_modes = '{0, 0, 78, 31, 0, 0, 78, 31};
    ring_restart(0, 4096);
    ring_restart(1, 4096);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty ring, stray data, zero payload, oversize, open-record drops.
    queue_beat(vrrb_pkg::K_CONS_HDR, '0, '0, '0);
    queue_beat(vrrb_pkg::K_PROD_DATA, '0, '0, 8'hFF);
    queue_beat(vrrb_pkg::K_CONS_DATA, '0, '0, '0);
    queue_beat(vrrb_pkg::K_PROD_HDR, 13'd0, 32'hFFFF_FFFF, '0);
    queue_beat(vrrb_pkg::K_CONS_HDR, '0, '0, '0);
    queue_beat(vrrb_pkg::K_PROD_HDR, 13'h1FFF, 32'h0, '0);
    queue_beat(vrrb_pkg::K_PROD_HDR, 13'd4096, 32'h1234_5678, '0);
    queue_beat(vrrb_pkg::K_PROD_HDR, 13'd3, 32'hA5C3_0F96, '0);
    queue_beat(vrrb_pkg::K_PROD_HDR, 13'd1, 32'h0, '0);
    queue_beat(vrrb_pkg::K_PROD_DATA, '0, '0, 8'h00);
    queue_beat(vrrb_pkg::K_PROD_DATA, '0, '0, 8'hFF);
    queue_beat(vrrb_pkg::K_PROD_DATA, '0, '0, 8'h5A);
    queue_beat(vrrb_pkg::K_CONS_HDR, '0, '0, '0);
    queue_beat(vrrb_pkg::K_CONS_HDR, '0, '0, '0);
    queue_beat(vrrb_pkg::K_CONS_DATA, '0, '0, '0);
    queue_beat(vrrb_pkg::K_CONS_DATA, '0, '0, '0);
    queue_beat(vrrb_pkg::K_CONS_DATA, '0, '0, '0);
    queue_beat(vrrb_pkg::K_CONS_DATA, '0, '0, '0);
    queue_beat(vrrb_pkg::K_CONS_HDR, '0, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) load_ring_size(sizes[ph]);
      send_idle_pct = idle_modes[ph];
      recv_stall_pct = stall_modes[ph];
      // Fill the ring behind a long receiver hold-off.
      if (ph == 4) begin
        hold_off_req = 400;
        repeat (40) queue_produce(13'($urandom_range(0, 6)));
      end
      queue_random(16);
    end

    wait (pending_items.size() == 0);
    cycles = 0;
    while (predicted_results.size() != 0 && cycles < 100000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (30) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (predicted_results.size() != 0)
        $display("ERROR: %0d results never arrived", predicted_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
